### hdl/midi_track_event_parser_assert.svh
// Assertion macros used by the checker file of the MIDI track event parser.
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// Clocked assertion that is switched off while reset is active.
`define MTEP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is active.
`define MTEP_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mtep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Types, codes and helper functions shared by the parser modules.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam logic [4:0] PAYLOAD_BYTES = 5'd16;
    localparam int STORE_DEPTH = 16;
    localparam int STORE_IDX_W = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam logic [7:0] STATUS_META = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [3:0] HI_PROGRAM = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_MLEN,
        PH_MDATA,
        PH_SLEN,
        PH_SDATA
    } mtep_phase_t;

    typedef enum logic [1:0] {
        RC_EVENT,
        RC_END,
        RC_TRUNC
    } mtep_code_t;

    typedef enum logic [1:0] {
        KIND_CHANNEL,
        KIND_META,
        KIND_SYSEX
    } mtep_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       cont;
        logic       is_meta;
        logic       is_sysex;
    } mtep_item_t;

    function automatic logic one_data_byte(input logic [7:0] st);
        one_data_byte = (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE);
    endfunction

endpackage

### hdl/mtep_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser channels
// Byte input channel and event result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface track_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] track_byte;
    logic       chunk_end;

    modport source (output valid, output track_byte, output chunk_end, input ready);
    modport sink (input valid, input track_byte, input chunk_end, output ready);
endinterface

interface track_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_code;
    logic [31:0] event_time;
    logic [1:0]  event_kind;
    logic [7:0]  meta_type;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
    logic [4:0]  payload_count;

    modport source (
        output valid, output result_code, output event_time, output event_kind,
        output meta_type, output status_byte, output first_data, output second_data,
        output payload_low, output payload_high, output payload_count, input ready
    );
    modport sink (
        input valid, input result_code, input event_time, input event_kind,
        input meta_type, input status_byte, input first_data, input second_data,
        input payload_low, input payload_high, input payload_count, output ready
    );
endinterface

### hdl/midi_track_event_parser.sv
`timescale 1ns / 1ps
// A byte that completes an event is written into the queue; the parser then reads it at the
// queue head and registers the result in its output stage.
// Throughput: one byte per cycle while results are taken; a stalled result holds the back end.
// A four-entry queue lets the input keep taking bytes while a result waits to be taken.
// Reset: rst_n clears the parse state, running time, running status and queue at once.
// ----------------------------------------------------------------------------
// MIDI track event parser
// Decodes a standard MIDI file track chunk into timed channel, meta and SysEx events.
// ----------------------------------------------------------------------------
module midi_track_event_parser
    import mtep_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    track_byte_if.sink    track_in,
    track_event_if.source event_out
);

    logic       queue_full;
    logic       push;
    mtep_item_t push_item;
    logic       pop;
    logic       not_empty;
    mtep_item_t head_item;

    mtep_front u_front (
        .track_in   (track_in),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    mtep_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (not_empty),
        .head_item (head_item)
    );

    mtep_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (not_empty),
        .item       (head_item),
        .pop        (pop),
        .event_out  (event_out)
    );

endmodule

### hdl/mtep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Accepts track bytes and tags each with the classes the parser needs.
// ----------------------------------------------------------------------------
module mtep_front
    import mtep_pkg::*;
(
    track_byte_if.sink track_in,
    input  logic       queue_full,
    output logic       push,
    output mtep_item_t push_item
);

    assign track_in.ready = !queue_full;
    assign push = track_in.valid && !queue_full;

    always_comb
    begin
        push_item.data = track_in.track_byte;
        push_item.last = track_in.chunk_end;
        push_item.cont = track_in.track_byte[7];
        push_item.is_meta = (track_in.track_byte == STATUS_META);
        push_item.is_sysex = (track_in.track_byte == STATUS_SYSEX) ||
                             (track_in.track_byte == STATUS_SYSEX_ESC);
    end

endmodule

### hdl/mtep_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser queue
// Short first-in first-out buffer between the front end and the parser.
// ----------------------------------------------------------------------------
module mtep_queue
    import mtep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  mtep_item_t push_item,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output mtep_item_t head_item
);

    localparam logic [QUEUE_PTR_W:0] QueueCount = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

    mtep_item_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [QUEUE_PTR_W:0]       count_reg;
    logic [QUEUE_PTR_W:0]       count_next;

    assign full = (count_reg == QueueCount);
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/mtep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser back end
// Runs the track parse state machine and holds each result in an output stage.
// ----------------------------------------------------------------------------
module mtep_back
    import mtep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  mtep_item_t  item,
    output logic        pop,
    track_event_if.source event_out
);

    mtep_phase_t  phase_reg;
    mtep_phase_t  phase_next;
    logic [31:0]  time_reg;
    logic [31:0]  time_next;
    logic [31:0]  len_reg;
    logic [31:0]  len_next;
    logic [7:0]   run_status_reg;
    logic [7:0]   run_status_next;
    logic [7:0]   type_reg;
    logic [7:0]   type_next;
    logic [31:0]  remain_reg;
    logic [31:0]  remain_next;
    logic [7:0]   store_reg [STORE_DEPTH];
    logic [7:0]   store_next [STORE_DEPTH];
    logic [4:0]   fill_reg;
    logic [4:0]   fill_next;
    logic [15:0]  chan_reg;
    logic [15:0]  chan_next;

    logic         out_valid_reg;
    logic [1:0]   code_reg;
    logic [1:0]   code_next;
    logic [31:0]  otime_reg;
    logic [1:0]   kind_reg;
    logic [1:0]   kind_next;
    logic [7:0]   mtype_reg;
    logic [7:0]   mtype_next;
    logic [7:0]   status_reg;
    logic [7:0]   status_next;
    logic [7:0]   d1_reg;
    logic [7:0]   d1_next;
    logic [7:0]   d2_reg;
    logic [7:0]   d2_next;
    logic [63:0]  plo_reg;
    logic [63:0]  plo_next;
    logic [63:0]  phi_reg;
    logic [63:0]  phi_next;
    logic [4:0]   pcount_reg;
    logic [4:0]   pcount_next;

    logic         fire;
    logic         done;
    logic         meta_out;
    logic         sysex_out;
    logic [31:0]  acc_shift;
    logic [7:0]   st;

    assign fire = item_valid && (!out_valid_reg || event_out.ready);
    assign pop = fire;
    assign acc_shift = {len_reg[24:0], item.data[6:0]};

    always_comb
    begin
        phase_next = phase_reg;
        time_next = time_reg;
        len_next = len_reg;
        run_status_next = run_status_reg;
        type_next = type_reg;
        remain_next = remain_reg;
        store_next = store_reg;
        fill_next = fill_reg;
        chan_next = chan_reg;
        done = 1'b0;
        meta_out = 1'b0;
        sysex_out = 1'b0;
        status_next = '0;
        d1_next = '0;
        d2_next = '0;
        st = chan_reg[7:0];
        if (fire)
        begin
            unique case (phase_reg)
                PH_DELTA:
                begin
                    if (item.cont)
                    begin
                        len_next = acc_shift;
                    end
                    else
                    begin
                        time_next = time_reg + acc_shift;
                        len_next = '0;
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    priority if (item.is_meta)
                    begin
                        phase_next = PH_MTYPE;
                    end
                    else if (item.is_sysex)
                    begin
                        len_next = '0;
                        phase_next = PH_SLEN;
                    end
                    else if (item.cont)
                    begin
                        chan_next = {8'h00, item.data};
                        phase_next = PH_DATA1;
                    end
                    else if (one_data_byte(run_status_reg))
                    begin
                        status_next = run_status_reg;
                        d1_next = item.data;
                        done = 1'b1;
                    end
                    else
                    begin
                        chan_next = {item.data, run_status_reg};
                        phase_next = PH_DATA2;
                    end
                end
                PH_DATA1:
                begin
                    if (one_data_byte(st))
                    begin
                        status_next = st;
                        d1_next = item.data;
                        run_status_next = st;
                        done = 1'b1;
                    end
                    else
                    begin
                        chan_next = {item.data, st};
                        phase_next = PH_DATA2;
                    end
                end
                PH_DATA2:
                begin
                    status_next = st;
                    d1_next = chan_reg[15:8];
                    d2_next = item.data;
                    run_status_next = st;
                    done = 1'b1;
                end
                PH_MTYPE:
                begin
                    type_next = item.data;
                    for (int i = 0; i < STORE_DEPTH; i++)
                    begin
                        store_next[i] = '0;
                    end
                    fill_next = '0;
                    len_next = '0;
                    phase_next = PH_MLEN;
                end
                PH_MLEN:
                begin
                    if (item.cont)
                    begin
                        len_next = acc_shift;
                    end
                    else
                    begin
                        remain_next = acc_shift;
                        len_next = '0;
                        if (acc_shift == '0)
                        begin
                            meta_out = 1'b1;
                            done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_MDATA;
                        end
                    end
                end
                PH_MDATA:
                begin
                    if (fill_reg < PAYLOAD_BYTES)
                    begin
                        store_next[fill_reg[STORE_IDX_W-1:0]] = item.data;
                        fill_next = fill_reg + 5'd1;
                    end
                    if (remain_reg != '0)
                    begin
                        remain_next = remain_reg - 32'd1;
                    end
                    if (remain_reg <= 32'd1)
                    begin
                        meta_out = 1'b1;
                        done = 1'b1;
                    end
                end
                PH_SLEN:
                begin
                    if (item.cont)
                    begin
                        len_next = acc_shift;
                    end
                    else
                    begin
                        remain_next = acc_shift;
                        len_next = '0;
                        if (acc_shift == '0)
                        begin
                            sysex_out = 1'b1;
                            done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SDATA;
                        end
                    end
                end
                default:
                begin
                    if (remain_reg != '0)
                    begin
                        remain_next = remain_reg - 32'd1;
                    end
                    if (remain_reg <= 32'd1)
                    begin
                        sysex_out = 1'b1;
                        done = 1'b1;
                    end
                end
            endcase
            if (done)
            begin
                phase_next = PH_DELTA;
            end
            if (item.last)
            begin
                phase_next = PH_DELTA;
                len_next = '0;
                remain_next = '0;
            end
        end
    end

    always_comb
    begin
        plo_next = '0;
        phi_next = '0;
        mtype_next = '0;
        pcount_next = '0;
        kind_next = KIND_CHANNEL;
        if (meta_out)
        begin
            for (int i = 0; i < 8; i++)
            begin
                plo_next[i*8 +: 8] = store_next[i];
                phi_next[i*8 +: 8] = store_next[i+8];
            end
            if (type_next == META_TEMPO)
            begin
                plo_next[31:0] = {8'h00, store_next[0], store_next[1], store_next[2]};
            end
            mtype_next = type_next;
            pcount_next = fill_next;
            kind_next = KIND_META;
        end
        else if (sysex_out)
        begin
            kind_next = KIND_SYSEX;
        end
        code_next = RC_EVENT;
        if (item.last)
        begin
            code_next = done ? RC_END : RC_TRUNC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DELTA;
            time_reg <= '0;
            len_reg <= '0;
            run_status_reg <= '0;
            type_reg <= '0;
            remain_reg <= '0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
            fill_reg <= '0;
            chan_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            time_reg <= time_next;
            len_reg <= len_next;
            run_status_reg <= run_status_next;
            type_reg <= type_next;
            remain_reg <= remain_next;
            store_reg <= store_next;
            fill_reg <= fill_next;
            chan_reg <= chan_next;
            if (fire && (done || item.last))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (event_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (done || item.last))
        begin
            code_reg <= code_next;
            otime_reg <= time_next;
            kind_reg <= done ? kind_next : KIND_CHANNEL;
            mtype_reg <= done ? mtype_next : 8'h00;
            status_reg <= done ? status_next : 8'h00;
            d1_reg <= done ? d1_next : 8'h00;
            d2_reg <= done ? d2_next : 8'h00;
            plo_reg <= done ? plo_next : 64'h0;
            phi_reg <= done ? phi_next : 64'h0;
            pcount_reg <= done ? pcount_next : 5'd0;
        end
    end

    assign event_out.valid = out_valid_reg;
    assign event_out.result_code = code_reg;
    assign event_out.event_time = otime_reg;
    assign event_out.event_kind = kind_reg;
    assign event_out.meta_type = mtype_reg;
    assign event_out.status_byte = status_reg;
    assign event_out.first_data = d1_reg;
    assign event_out.second_data = d2_reg;
    assign event_out.payload_low = plo_reg;
    assign event_out.payload_high = phi_reg;
    assign event_out.payload_count = pcount_reg;

endmodule

### hdl/mtep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_assert.svh"

module mtep_checker
    import mtep_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_code,
    input logic [31:0] event_time,
    input logic [1:0]  event_kind,
    input logic [7:0]  status_byte,
    input logic [63:0] payload_low,
    input logic [4:0]  payload_count
);

    `MTEP_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(event_time), "stalled result changed")
    `MTEP_ASSERT(a_code_legal, out_valid |-> result_code != 2'd3, "illegal result code")
    `MTEP_ASSERT(a_trunc_clean, out_valid && result_code == RC_TRUNC |-> event_kind == KIND_CHANNEL && status_byte == 8'h00 && payload_count == 5'd0, "truncated result carries data")
    `MTEP_ASSERT(a_payload_meta, out_valid && event_kind != KIND_META |-> payload_count == 5'd0 && payload_low == 64'h0, "payload on non-meta result")

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (event_out.valid),
    .out_ready     (event_out.ready),
    .result_code   (event_out.result_code),
    .event_time    (event_out.event_time),
    .event_kind    (event_out.event_kind),
    .status_byte   (event_out.status_byte),
    .payload_low   (event_out.payload_low),
    .payload_count (event_out.payload_count)
);

### dv/track_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track event checker
// Watches the byte and event channels of the MIDI track event parser. It
// decodes every accepted byte with its own copy of the parse state, queues
// the events that should appear, and compares each accepted event with the
// oldest one in the queue.
// ----------------------------------------------------------------------------
module track_event_checker
    import mtep_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    track_byte_if  byte_mon,
    track_event_if event_mon,
    output int     fail_count,
    output int     pending
);

    typedef struct packed {
        mtep_code_t  code;
        logic [31:0] etime;
        mtep_kind_t  kind;
        logic [7:0]  mtype;
        logic [7:0]  status;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [63:0] plow;
        logic [63:0] phigh;
        logic [4:0]  pcount;
    } track_event_t;

    mtep_phase_t  phase;
    logic [31:0]  track_time;
    logic [31:0]  quantity;
    logic [7:0]   run_status;
    logic [7:0]   held_type;
    logic [31:0]  skip_left;
    logic [7:0]   payload [16];
    logic [4:0]   payload_kept;
    logic [15:0]  chan_bytes;
    track_event_t expected_events [$];
    int           fails;

    function automatic logic takes_one_data(input logic [7:0] st);
        return (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE);
    endfunction

    function automatic void load_meta(inout track_event_t ev);
        int i;
        for (i = 0; i < 8; i++) begin
            ev.plow[8*i +: 8]  = payload[i];
            ev.phigh[8*i +: 8] = payload[i + 8];
        end
        if (held_type == META_TEMPO) begin
            ev.plow[31:0] = {8'h00, payload[0], payload[1], payload[2]};
        end
        ev.kind   = KIND_META;
        ev.mtype  = held_type;
        ev.pcount = payload_kept;
    endfunction

    function automatic string describe(input track_event_t ev);
        return $sformatf({"code=%0d time=%h kind=%0d type=%h status=%h d1=%h d2=%h ",
                          "low=%h high=%h count=%0d"},
                         ev.code, ev.etime, ev.kind, ev.mtype, ev.status, ev.data1,
                         ev.data2, ev.plow, ev.phigh, ev.pcount);
    endfunction

    function automatic void parse_track_byte(input logic [7:0] b, input logic last);
        track_event_t ev;
        logic         done;
        logic [7:0]   st;
        ev       = '0;
        ev.etime = track_time;
        done     = 1'b0;
        case (phase)
            PH_DELTA:
            begin
                quantity = {quantity[24:0], b[6:0]};
                if (!b[7])
                begin
                    track_time = track_time + quantity;
                    ev.etime   = track_time;
                    quantity   = '0;
                    phase      = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (b == STATUS_META)
                begin
                    phase = PH_MTYPE;
                end
                else if (b == STATUS_SYSEX || b == STATUS_SYSEX_ESC)
                begin
                    quantity = '0;
                    phase    = PH_SLEN;
                end
                else if (b[7])
                begin
                    chan_bytes = {8'h00, b};
                    phase      = PH_DATA1;
                end
                else
                begin
                    st = run_status;
                    if (takes_one_data(st))
                    begin
                        ev.kind   = KIND_CHANNEL;
                        ev.status = st;
                        ev.data1  = b;
                        done      = 1'b1;
                    end
                    else
                    begin
                        chan_bytes = {b, st};
                        phase      = PH_DATA2;
                    end
                end
            end
            PH_DATA1:
            begin
                st = chan_bytes[7:0];
                if (takes_one_data(st))
                begin
                    ev.kind    = KIND_CHANNEL;
                    ev.status  = st;
                    ev.data1   = b;
                    run_status = st;
                    done       = 1'b1;
                end
                else
                begin
                    chan_bytes = {b, st};
                    phase      = PH_DATA2;
                end
            end
            PH_DATA2:
            begin
                ev.kind    = KIND_CHANNEL;
                ev.status  = chan_bytes[7:0];
                ev.data1   = chan_bytes[15:8];
                ev.data2   = b;
                run_status = chan_bytes[7:0];
                done       = 1'b1;
            end
            PH_MTYPE:
            begin
                held_type = b;
                foreach (payload[i]) payload[i] = 8'h00;
                payload_kept = '0;
                quantity     = '0;
                phase        = PH_MLEN;
            end
            PH_MLEN:
            begin
                quantity = {quantity[24:0], b[6:0]};
                if (!b[7])
                begin
                    skip_left = quantity;
                    quantity  = '0;
                    if (skip_left == 0)
                    begin
                        load_meta(ev);
                        done = 1'b1;
                    end
                    else
                    begin
                        phase = PH_MDATA;
                    end
                end
            end
            PH_MDATA:
            begin
                if (payload_kept < PAYLOAD_BYTES)
                begin
                    payload[payload_kept[3:0]] = b;
                    payload_kept = payload_kept + 5'd1;
                end
                if (skip_left != 0) skip_left = skip_left - 1;
                if (skip_left == 0)
                begin
                    load_meta(ev);
                    done = 1'b1;
                end
            end
            PH_SLEN:
            begin
                quantity = {quantity[24:0], b[6:0]};
                if (!b[7])
                begin
                    skip_left = quantity;
                    quantity  = '0;
                    if (skip_left == 0)
                    begin
                        ev.kind = KIND_SYSEX;
                        done    = 1'b1;
                    end
                    else
                    begin
                        phase = PH_SDATA;
                    end
                end
            end
            default:
            begin
                if (skip_left != 0) skip_left = skip_left - 1;
                if (skip_left == 0)
                begin
                    ev.kind = KIND_SYSEX;
                    done    = 1'b1;
                end
            end
        endcase
        if (done) phase = PH_DELTA;
        if (last)
        begin
            phase     = PH_DELTA;
            quantity  = '0;
            skip_left = '0;
            if (done)
            begin
                ev.code = RC_END;
            end
            else
            begin
                ev       = '0;
                ev.etime = track_time;
                ev.code  = RC_TRUNC;
            end
            expected_events.push_back(ev);
        end
        else if (done)
        begin
            ev.code = RC_EVENT;
            expected_events.push_back(ev);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : compare_events
        track_event_t seen;
        track_event_t want;
        if (!rst_n)
        begin
            phase        = PH_DELTA;
            track_time   = '0;
            quantity     = '0;
            run_status   = '0;
            held_type    = '0;
            skip_left    = '0;
            payload_kept = '0;
            chan_bytes   = '0;
            foreach (payload[i]) payload[i] = 8'h00;
            expected_events.delete();
            fails = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (byte_mon.valid === 1'b1 && byte_mon.ready === 1'b1)
            begin
                parse_track_byte(byte_mon.track_byte, byte_mon.chunk_end);
            end
            if (event_mon.valid === 1'b1 && event_mon.ready === 1'b1)
            begin
                seen = {mtep_code_t'(event_mon.result_code), event_mon.event_time,
                        mtep_kind_t'(event_mon.event_kind), event_mon.meta_type,
                        event_mon.status_byte, event_mon.first_data, event_mon.second_data,
                        event_mon.payload_low, event_mon.payload_high,
                        event_mon.payload_count};
                if (expected_events.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                    begin
                        $display("[%0t] event with none expected: %s", $realtime,
                                 describe(seen));
                    end
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (seen !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("[%0t] event mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe(want), describe(seen));
                        end
                    end
                end
            end
            fail_count <= fails;
            pending    <= expected_events.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Feeds the parser a short hand-written track and then random events with
// random deltas, meta, SysEx, running status, noise and chunk ends, while
// both channels stall at random. The checker beside the parser does the
// comparison; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
    import mtep_pkg::*;
();

    localparam int RANDOM_BYTES = 550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;

    logic       clk;
    logic       rst_n;
    int         fail_count;
    int         pending_count;
    int         bytes_sent;
    int         cut_at;
    bit         src_gaps;
    bit         sink_gaps;
    bit         calm;
    bit         hold_go;
    bit         hold_done;
    logic [7:0] stim_status;
    logic [7:0] event_bytes [$];
    logic [7:0] directed_track [$];

    track_byte_if  byte_ch ();
    track_event_if event_ch ();

    midi_track_event_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .track_in  (byte_ch),
        .event_out (event_ch)
    );

    track_event_checker event_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_mon   (byte_ch),
        .event_mon  (event_ch),
        .fail_count (fail_count),
        .pending    (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : sink_ready
        int stall_left;
        int hold_left;
        stall_left     = 0;
        hold_left      = 0;
        event_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                event_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                event_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_gaps && !calm && $urandom_range(0, 4) == 0)
            begin
                event_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end
            else
            begin
                event_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic one_data_status(input logic [7:0] st);
        return (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (src_gaps && !calm && $urandom_range(0, 4) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.track_byte <= b;
        byte_ch.chunk_end  <= last;
        @(posedge clk);
        while (byte_ch.ready !== 1'b1) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic push_quantity(input logic [31:0] value, input int pad);
        logic [6:0] groups [$];
        int         i;
        do
        begin
            groups.push_front(value[6:0]);
            value = value >> 7;
        end
        while (value != 0);
        repeat (pad) groups.push_front(7'h00);
        for (i = 0; i < groups.size(); i++)
        begin
            event_bytes.push_back({i != groups.size() - 1, groups[i]});
        end
    endtask

    task automatic push_long_quantity(input int n);
        logic [7:0] b;
        int         i;
        for (i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 127));
            if (i != n - 1) b = b | 8'h80;
            event_bytes.push_back(b);
        end
    endtask

    task automatic push_channel(input logic [7:0] st, input bit explicit);
        if (explicit) event_bytes.push_back(st);
        event_bytes.push_back(8'($urandom_range(0, 127)));
        if (!one_data_status(st)) event_bytes.push_back(8'($urandom_range(0, 127)));
    endtask

    task automatic build_track_event();
        int         pick;
        int         len;
        logic [7:0] st;
        bit         force_cut;
        event_bytes.delete();
        force_cut = 1'b0;
        pick = $urandom_range(0, 19);
        if (pick < 10) push_quantity($urandom_range(0, 127), 0);
        else if (pick < 15) push_quantity($urandom_range(0, 16383), 0);
        else if (pick < 17) push_quantity($urandom, 0);
        else if (pick < 19) push_long_quantity($urandom_range(5, 7));
        else push_quantity($urandom_range(0, 127), $urandom_range(1, 3));

        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            stim_status = st;
            push_channel(st, 1'b1);
        end
        else if (pick < 50)
        begin
            push_channel(stim_status, 1'b0);
        end
        else if (pick < 55)
        begin
            st = 8'($urandom_range(8'hF1, 8'hFE));
            if (st == STATUS_SYSEX_ESC) st = 8'hF8;
            stim_status = st;
            push_channel(st, 1'b1);
        end
        else if (pick < 80)
        begin
            event_bytes.push_back(STATUS_META);
            pick = $urandom_range(0, 7);
            if (pick < 2)
            begin
                event_bytes.push_back(META_TEMPO);
                len = (pick == 0) ? 3 : $urandom_range(0, 6);
            end
            else if (pick == 2)
            begin
                event_bytes.push_back(8'h2F);
                len = 0;
            end
            else
            begin
                event_bytes.push_back(8'($urandom_range(0, 255)));
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(0, 8);
            end
            push_quantity(len, ($urandom_range(0, 9) == 0) ? 1 : 0);
            repeat (len) event_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick < 92)
        begin
            event_bytes.push_back($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_SYSEX_ESC);
            len = $urandom_range(0, 12);
            push_quantity(len, 0);
            repeat (len) event_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick < 96)
        begin
            repeat ($urandom_range(1, 6)) event_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 1))
            begin
                event_bytes.push_back(STATUS_META);
                event_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                event_bytes.push_back(STATUS_SYSEX);
            end
            push_long_quantity($urandom_range(5, 6));
            repeat ($urandom_range(0, 20)) event_bytes.push_back(8'($urandom_range(0, 255)));
            force_cut = 1'b1;
        end

        pick = $urandom_range(0, 29);
        if (force_cut || pick == 2) cut_at = event_bytes.size() - 1;
        else if (pick < 2) cut_at = $urandom_range(0, event_bytes.size() - 1);
        else cut_at = -1;
        if (cut_at >= 0)
        begin
            while (event_bytes.size() > cut_at + 1) void'(event_bytes.pop_back());
        end
    endtask

    initial
    begin : stimulus
        int i;
        int random_end;
        rst_n              = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.track_byte = 8'h00;
        byte_ch.chunk_end  = 1'b0;
        bytes_sent         = 0;
        src_gaps           = 1'b1;
        sink_gaps          = 1'b1;
        calm               = 1'b0;
        hold_go            = 1'b0;
        hold_done          = 1'b0;
        stim_status        = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_track = '{8'h00, 8'h12, 8'h34,
                           8'h7F, 8'h90, 8'h00, 8'h7F,
                           8'h00, 8'h7F, 8'h00,
                           8'h81, 8'h00, 8'hC5, 8'h7F,
                           8'h00, 8'h01,
                           8'h00, STATUS_META, META_TEMPO, 8'h03, 8'hFF, 8'hA1, 8'h20,
                           8'h00, STATUS_SYSEX, 8'h00,
                           8'h00, STATUS_META, 8'h2F, 8'h00};
        for (i = 0; i < directed_track.size(); i++)
        begin
            send_byte(directed_track[i], i == directed_track.size() - 1);
        end
        stim_status = 8'hC5;

        random_end = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end)
        begin
            if ($urandom_range(0, 24) == 0) src_gaps = !src_gaps;
            if ($urandom_range(0, 24) == 0) sink_gaps = !sink_gaps;
            if (!hold_done && bytes_sent >= 200)
            begin
                hold_done = 1'b1;
                hold_go   = 1'b1;
                src_gaps  = 1'b0;
            end
            if (bytes_sent >= random_end - 80) calm = 1'b1;
            build_track_event();
            for (i = 0; i < event_bytes.size(); i++)
            begin
                send_byte(event_bytes[i], i == cut_at);
            end
        end
        byte_ch.valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/mtep_pkg.sv
hdl/mtep_if.sv
hdl/mtep_front.sv
hdl/mtep_queue.sv
hdl/mtep_back.sv
hdl/midi_track_event_parser.sv
hdl/mtep_checker.sv
dv/track_event_checker.sv
dv/tb_top.sv
